@@ hw/rtl/bis_pkg.sv @@
// Shared types, constants and helpers for the body integrate step block.
`timescale 1ns / 1ps
package bis_pkg;

  localparam int unsigned FRAC_W = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WORLD_WIDTH  = 2'd0,
    REG_WORLD_HEIGHT = 2'd1,
    REG_MAX_SPEED    = 2'd2
  } cfg_reg_t;

  localparam logic [14:0] WORLD_WIDTH_RST  = 15'd640;
  localparam logic [14:0] WORLD_HEIGHT_RST = 15'd480;
  localparam logic [30:0] MAX_SPEED_RST    = 31'd13107200;

  // body state carried down the pipe
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        dt;
    logic               over;
  } body_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor(v * dt / 2^16) + base, saturated; prod is v * dt
  function automatic logic signed [31:0] add_floor(input logic signed [31:0] base,
                                                   input logic signed [48:0] prod);
    logic signed [33:0] s;
    s = {base[31], base[31], base} + {prod[48], prod[48:FRAC_W]};
    return sat34(s);
  endfunction

endpackage

@@ hw/rtl/body_integrate_step_top.sv @@
// Top level of the body integrate step block.
`timescale 1ns / 1ps
// One semi-implicit Euler step per 2-D body in Q16.16: v' = v + a*dt, |v'|
// clamped to max_speed keeping direction, p' = p + v'*dt, each axis wrapped
// once into the world. The block takes one word per cycle while the output
// is not stalled and delivers one result word per input word, in order,
// through 4 velocity stages, 32 square-root stages, 33 rescale stages and 4
// position stages, the last being the output register. The whole pipe
// advances together: it moves whenever the output register is empty or
// being taken, so in_tready = !out_tvalid || out_tready. Write the
// configuration only while the pipe is empty.
module body_integrate_step_top import bis_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, time_step (low bit up)
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y (low bit up)
  output logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  logic [14:0] world_width_r, world_height_r;
  logic [30:0] max_speed_r;
  logic        en;

  logic        v_valid, s_valid, d_valid;
  body_t       v_body, s_body, d_body;
  logic [63:0] v_sumsq;
  logic [31:0] s_root;
  logic signed [31:0] o_px, o_py, o_vx, o_vy;

  // global advance
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_width_r  <= WORLD_WIDTH_RST;
      world_height_r <= WORLD_HEIGHT_RST;
      max_speed_r    <= MAX_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WORLD_WIDTH:  world_width_r  <= cfg_wdata[14:0];
        REG_WORLD_HEIGHT: world_height_r <= cfg_wdata[14:0];
        REG_MAX_SPEED:    max_speed_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bis_vel u_vel (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid && en),
    .pos_x    (in_tdata[31:0]),
    .pos_y    (in_tdata[63:32]),
    .vel_x    (in_tdata[95:64]),
    .vel_y    (in_tdata[127:96]),
    .acc_x    (in_tdata[159:128]),
    .acc_y    (in_tdata[191:160]),
    .dt       (in_tdata[207:192]),
    .max_speed(max_speed_r),
    .out_valid(v_valid),
    .out_body (v_body),
    .out_sumsq(v_sumsq)
  );

  bis_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (v_valid),
    .in_rad   (v_sumsq),
    .in_body  (v_body),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_body (s_body)
  );

  bis_div u_div (
    .clk, .rst_n, .en,
    .in_valid (s_valid),
    .in_len   (s_root),
    .in_body  (s_body),
    .max_speed(max_speed_r),
    .out_valid(d_valid),
    .out_body (d_body)
  );

  bis_pos u_pos (
    .clk, .rst_n, .en,
    .in_valid    (d_valid),
    .in_body     (d_body),
    .world_width (world_width_r),
    .world_height(world_height_r),
    .out_valid   (out_tvalid),
    .out_pos_x   (o_px),
    .out_pos_y   (o_py),
    .out_vel_x   (o_vx),
    .out_vel_y   (o_vy)
  );

  assign out_tdata = {o_vy, o_vx, o_py, o_px};

endmodule

@@ hw/rtl/bis_vel.sv @@
// Velocity update, squared speed and limit test: four register stages.
`timescale 1ns / 1ps
module bis_vel import bis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] acc_x,
  input  logic signed [31:0] acc_y,
  input  logic [15:0]        dt,
  input  logic [30:0]        max_speed,
  output logic               out_valid,
  output body_t              out_body,
  output logic [63:0]        out_sumsq
);

  logic [3:0]         vld_r;
  body_t              b1_r, b2_r, b3_r, b4_r;
  body_t              b2_nxt, b4_nxt;
  logic signed [48:0] prx_r, pry_r;
  logic [63:0]        sqx_r, sqy_r, sum_r;
  logic [63:0]        sum_nxt;
  logic [61:0]        lsq_r;
  logic [31:0]        magx, magy;

  assign magx = b2_r.vel_x[31] ? 32'(-b2_r.vel_x) : 32'(b2_r.vel_x);
  assign magy = b2_r.vel_y[31] ? 32'(-b2_r.vel_y) : 32'(b2_r.vel_y);

  always_comb begin
    b2_nxt       = b1_r;
    b2_nxt.vel_x = add_floor(b1_r.vel_x, prx_r);
    b2_nxt.vel_y = add_floor(b1_r.vel_y, pry_r);
    sum_nxt      = sqx_r + sqy_r;
    b4_nxt       = b3_r;
    b4_nxt.over  = sum_nxt > {2'b00, lsq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: a * dt
      b1_r  <= '{pos_x: pos_x, pos_y: pos_y, vel_x: vel_x, vel_y: vel_y, dt: dt, over: 1'b0};
      prx_r <= acc_x * $signed({17'd0, dt});
      pry_r <= acc_y * $signed({17'd0, dt});
      // stage 2: v + a*dt
      b2_r  <= b2_nxt;
      // stage 3: squares
      b3_r  <= b2_r;
      sqx_r <= magx * magx;
      sqy_r <= magy * magy;
      lsq_r <= max_speed * max_speed;
      // stage 4: sum and limit test
      b4_r  <= b4_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = vld_r[3];
  assign out_body  = b4_r;
  assign out_sumsq = sum_r;

endmodule

@@ hw/rtl/bis_sqrt.sv @@
// Pipelined integer square root, one root bit per stage (32 stages).
`timescale 1ns / 1ps
module bis_sqrt import bis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_rad,
  input  body_t       in_body,
  output logic        out_valid,
  output logic [31:0] out_root,
  output body_t       out_body
);

  logic [63:0] rad_r  [1:32];
  logic [33:0] rem_r  [1:32];
  logic [31:0] root_r [1:32];
  body_t       body_r [1:32];
  logic [32:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[31:1], in_valid};
    end
  end

  for (genvar i = 0; i < 32; i++) begin : g_stage
    logic [63:0] rad_c;
    logic [33:0] rem_c;
    logic [31:0] root_c;
    body_t       body_c;
    logic [35:0] rem_sh, trial, diff;
    logic        ge;
    if (i == 0) begin : g_first
      assign rad_c  = in_rad;
      assign rem_c  = '0;
      assign root_c = '0;
      assign body_c = in_body;
    end else begin : g_next
      assign rad_c  = rad_r[i];
      assign rem_c  = rem_r[i];
      assign root_c = root_r[i];
      assign body_c = body_r[i];
    end
    assign rem_sh = {rem_c, rad_c[63:62]};
    assign trial  = {2'b00, root_c, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i+1]  <= {rad_c[61:0], 2'b00};
        rem_r[i+1]  <= ge ? diff[33:0] : rem_sh[33:0];
        root_r[i+1] <= {root_c[30:0], ge};
        body_r[i+1] <= body_c;
      end
    end
  end

  assign out_valid = vld_r[32];
  assign out_root  = root_r[32];
  assign out_body  = body_r[32];

endmodule

@@ hw/rtl/bis_div.sv @@
// Speed rescale: |v| * limit / length by a pipelined restoring divider per axis.
`timescale 1ns / 1ps
module bis_div import bis_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_len,
  input  body_t       in_body,
  input  logic [30:0] max_speed,
  output logic        out_valid,
  output body_t       out_body
);

  localparam int unsigned QW = 31;

  logic [62:0]   remx_r [0:QW];
  logic [62:0]   remy_r [0:QW];
  logic [QW-1:0] qx_r   [0:QW];
  logic [QW-1:0] qy_r   [0:QW];
  logic [31:0]   len_r  [0:QW];
  body_t         body_r [0:QW];
  logic [QW+1:0] vld_r;
  logic [31:0]   magx, magy;
  body_t         fin_r, fin_nxt;

  assign magx = in_body.vel_x[31] ? 32'(-in_body.vel_x) : 32'(in_body.vel_x);
  assign magy = in_body.vel_y[31] ? 32'(-in_body.vel_y) : 32'(in_body.vel_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW:0], in_valid};
    end
  end

  // dividend products
  always_ff @(posedge clk) begin
    if (en) begin
      remx_r[0] <= magx * max_speed;
      remy_r[0] <= magy * max_speed;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      len_r[0]  <= in_len;
      body_r[0] <= in_body;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [62:0] d;
    logic        gex, gey;
    assign d   = {31'd0, len_r[k]} << (QW - 1 - k);
    assign gex = remx_r[k] >= d;
    assign gey = remy_r[k] >= d;
    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[k+1] <= gex ? remx_r[k] - d : remx_r[k];
        remy_r[k+1] <= gey ? remy_r[k] - d : remy_r[k];
        qx_r[k+1]   <= {qx_r[k][QW-2:0], gex};
        qy_r[k+1]   <= {qy_r[k][QW-2:0], gey};
        len_r[k+1]  <= len_r[k];
        body_r[k+1] <= body_r[k];
      end
    end
  end

  // sign back on, only when over the limit
  always_comb begin
    fin_nxt = body_r[QW];
    if (body_r[QW].over) begin
      fin_nxt.vel_x = body_r[QW].vel_x[31] ? -$signed({1'b0, qx_r[QW]})
                                           :  $signed({1'b0, qx_r[QW]});
      fin_nxt.vel_y = body_r[QW].vel_y[31] ? -$signed({1'b0, qy_r[QW]})
                                           :  $signed({1'b0, qy_r[QW]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  assign out_valid = vld_r[QW+1];
  assign out_body  = fin_r;

endmodule

@@ hw/rtl/bis_pos.sv @@
// Position update and world wrap; the last stage is the output register.
`timescale 1ns / 1ps
module bis_pos import bis_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  body_t              in_body,
  input  logic [14:0]        world_width,
  input  logic [14:0]        world_height,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y
);

  logic [3:0]         vld_r;
  body_t              b1_r, b2_r, b3_r, b4_r;
  body_t              b2_nxt, b3_nxt, b4_nxt;
  logic signed [48:0] prx_r, pry_r;
  logic signed [31:0] sw, sh;

  assign sw = $signed({1'b0, world_width, 16'd0});
  assign sh = $signed({1'b0, world_height, 16'd0});

  always_comb begin
    b2_nxt       = b1_r;
    b2_nxt.pos_x = add_floor(b1_r.pos_x, prx_r);
    b2_nxt.pos_y = add_floor(b1_r.pos_y, pry_r);
    b3_nxt       = b2_r;
    b3_nxt.pos_x = b2_r.pos_x[31] ? b2_r.pos_x + sw : b2_r.pos_x;
    b3_nxt.pos_y = b2_r.pos_y[31] ? b2_r.pos_y + sh : b2_r.pos_y;
    b4_nxt       = b3_r;
    b4_nxt.pos_x = (b3_r.pos_x >= sw) ? b3_r.pos_x - sw : b3_r.pos_x;
    b4_nxt.pos_y = (b3_r.pos_y >= sh) ? b3_r.pos_y - sh : b3_r.pos_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r  <= in_body;
      prx_r <= in_body.vel_x * $signed({17'd0, in_body.dt});
      pry_r <= in_body.vel_y * $signed({17'd0, in_body.dt});
      b2_r  <= b2_nxt;
      b3_r  <= b3_nxt;
      b4_r  <= b4_nxt;
    end
  end

  assign out_valid = vld_r[3];
  assign out_pos_x = b4_r.pos_x;
  assign out_pos_y = b4_r.pos_y;
  assign out_vel_x = b4_r.vel_x;
  assign out_vel_y = b4_r.vel_y;

endmodule

@@ hw/rtl/bis_checker.sv @@
// Port-level assertions for the body integrate step block, bound to the top.
`timescale 1ns / 1ps
module bis_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output side");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word present right after reset");

endmodule

bind body_integrate_step_top bis_checker u_bis_checker (.*);

@@ bench/body_integrate_step_top_test.sv @@
// Self-checking testbench for the body integrate step block.
`timescale 1ns / 1ps
module body_integrate_step_top_test;
  import bis_pkg::*;

  localparam int LATENCY     = 75;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 1330;

  typedef struct {
    logic signed [31:0] px, py, vx, vy, ax, ay;
    logic [15:0] dt;
  } body_in_t;

  typedef struct {
    logic signed [31:0] px, py, vx, vy;
  } body_out_t;

  // directed row: input, and an optional typed-in result
  typedef struct {
    body_in_t  b;
    bit        fixed;
    body_out_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, time_step (lowest bits first)
  logic [207:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // new_pos_x, new_pos_y, new_vel_x, new_vel_y (lowest bits first)
  logic [127:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = REG_WORLD_WIDTH;
  logic [30:0] cfg_wdata = '0;

  body_integrate_step_top u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor copy of the registers
  logic [14:0] width_q = WORLD_WIDTH_RST;
  logic [14:0] height_q = WORLD_HEIGHT_RST;
  logic [30:0] speed_q = MAX_SPEED_RST;

  body_out_t expected_q[$];
  int n_errors = 0;
  int n_checked = 0;
  int cycles = 0;
  bit sending = 1'b0;
  bit quiet_mode = 1'b0;   // no idling on either side
  bit hold_rx = 1'b0;      // long receiver hold-off

  // value times step, floored back to Q16.16
  function automatic longint step_mul(longint v, logic [15:0] dt);
    longint p;
    p = v * longint'(dt);
    return p >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap(longint p, logic [14:0] size);
    longint s;
    s = longint'(size) << 16;
    if (p < 0) p += s;
    if (p >= s) p -= s;
    return p;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint limit_axis(longint v, longint unsigned lim,
                                        longint unsigned len);
    longint unsigned m, q;
    m = (v < 0) ? -v : v;
    q = (m * lim) / len;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic body_out_t integrate(body_in_t b);
    longint vx, vy, px, py;
    longint unsigned mx, my, sq, lim, len;
    body_out_t r;
    vx = clamp32(longint'(b.vx) + step_mul(b.ax, b.dt));
    vy = clamp32(longint'(b.vy) + step_mul(b.ay, b.dt));
    mx = (vx < 0) ? -vx : vx;
    my = (vy < 0) ? -vy : vy;
    sq = mx * mx + my * my;
    lim = speed_q;
    if (sq > lim * lim) begin
      len = root_floor(sq);
      vx = limit_axis(vx, lim, len);
      vy = limit_axis(vy, lim, len);
    end
    px = wrap(clamp32(longint'(b.px) + step_mul(vx, b.dt)), width_q);
    py = wrap(clamp32(longint'(b.py) + step_mul(vy, b.dt)), height_q);
    r.px = px[31:0];
    r.py = py[31:0];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] any32();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic body_in_t random_body();
    body_in_t b;
    b.px = any32();
    b.py = any32();
    b.vx = any32();
    b.vy = any32();
    b.ax = any32();
    b.ay = any32();
    b.dt = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom());
    // mostly positions inside a small world with plausible motion
    if ($urandom_range(0, 99) < 60) begin
      b.px = $urandom_range(0, 32'h0300_0000) - 32'h0080_0000;
      b.py = $urandom_range(0, 32'h0300_0000) - 32'h0080_0000;
      b.vx = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      b.vy = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    end
    return b;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WORLD_WIDTH:  width_q = val[14:0];
      REG_WORLD_HEIGHT: height_q = val[14:0];
      default:          speed_q = val;
    endcase
  endtask

  // send one word; the result is predicted when it is accepted
  task automatic send_body(body_in_t b, bit fixed, body_out_t r);
    while (!quiet_mode && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {b.dt, b.ay, b.ax, b.vy, b.vx, b.py, b.px};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(fixed ? r : integrate(b));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // receiver: random stalls, unless holding off or in the quiet stretch
  always @(posedge clk) begin
    if (!rst_n || hold_rx) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_mode || ($urandom_range(0, 99) >= 31);
    end
  end

  // scoreboard
  always @(posedge clk) begin
    body_out_t e, g;
    if (rst_n && out_tvalid && out_tready) begin
      g.px = out_tdata[31:0];
      g.py = out_tdata[63:32];
      g.vx = out_tdata[95:64];
      g.vy = out_tdata[127:96];
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e != g) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch #%0d: exp pos %h %h vel %h %h, got pos %h %h vel %h %h",
                     n_checked, e.px, e.py, e.vx, e.vy, g.px, g.py, g.vx, g.vy);
          end
        end
      end
    end
  end

  // long hold-off while the sender keeps offering random words
  initial begin
    int k;
    wait (sending);
    repeat (100) @(posedge clk);
    hold_rx = 1'b1;
    for (k = 0; k < 200; k++) @(posedge clk);
    hold_rx = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** body_integrate_step_top: FAILED **");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(logic signed [31:0] px, py, vx, vy, ax, ay,
                              logic [15:0] dt);
    row_t t;
    t.b = '{px, py, vx, vy, ax, ay, dt};
    t.fixed = 1'b0;
    t.r = '{0, 0, 0, 0};
    return t;
  endfunction

  initial begin
    row_t t;
    body_out_t none;
    int i, phase;
    none = '{0, 0, 0, 0};
    // zero step at rest: position and velocity pass through
    t = mk(32'sh0001_0000, 32'sh0002_0000, 0, 0, 0, 0, 0);
    t.fixed = 1; t.r = '{32'sh0001_0000, 32'sh0002_0000, 0, 0};
    rows.push_back(t);
    // negative position wraps up by the default width 640 / height 480
    t = mk(-32'sh0001_0000, -32'sh0001_0000, 0, 0, 0, 0, 0);
    t.fixed = 1; t.r = '{32'sh027f_0000, 32'sh01df_0000, 0, 0};
    rows.push_back(t);
    // at the size exactly: wraps to zero
    t = mk(32'sh0280_0000, 32'sh01e0_0000, 0, 0, 0, 0, 0);
    t.fixed = 1; t.r = '{0, 0, 0, 0};
    rows.push_back(t);
    // far outside stays outside after one wrap
    rows.push_back(mk(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0, 16'hffff));
    // above the limit on one axis: clamps to exactly the limit
    t = mk(0, 0, 32'sh0190_0000, 0, 0, 0, 0);
    t.fixed = 1; t.r = '{0, 0, 32'sh00c8_0000, 0};
    rows.push_back(t);
    rows.push_back(mk(0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      32'sh7fff_ffff, 16'hffff));
    rows.push_back(mk(0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 16'hffff));
    rows.push_back(mk(32'sh0010_0000, 32'sh0010_0000, 32'sh0050_0000,
                      -32'sh0030_0000, -32'sh0001_0001, 32'sh0000_0003, 16'h8000));
    rows.push_back(mk(32'sh0100_0000, 32'sh0000_8000, -1, -1, -1, -1, 16'h0001));
    rows.push_back(mk(-32'sh0000_0001, 32'sh01df_ffff, 32'sh0080_0000,
                      32'sh0080_0000, 0, 0, 16'h4000));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset settings
    foreach (rows[i]) send_body(rows[i].b, rows[i].fixed, rows[i].fixed ? rows[i].r : none);
    drain();

    // extremes of the registers: smallest world, zero limit, then full range
    write_reg(REG_WORLD_WIDTH, 31'd1);
    write_reg(REG_WORLD_HEIGHT, 31'd1);
    write_reg(REG_MAX_SPEED, 31'd0);
    for (i = 0; i < 6; i++) send_body(rows[i].b, 1'b0, none);
    drain();
    write_reg(REG_WORLD_WIDTH, 31'd32767);
    write_reg(REG_WORLD_HEIGHT, 31'd32767);
    write_reg(REG_MAX_SPEED, 31'h7fff_ffff);
    for (i = 0; i < 6; i++) send_body(rows[i].b, 1'b0, none);
    drain();

    // random phases, settings changed between them
    sending = 1'b1;
    for (phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        write_reg(REG_WORLD_WIDTH, 31'($urandom_range(1, 32767)));
        write_reg(REG_WORLD_HEIGHT, 31'($urandom_range(1, 32767)));
        write_reg(REG_MAX_SPEED, ($urandom_range(0, 3) == 0) ?
                  31'($urandom()) : 31'($urandom_range(0, 32'h0200_0000)));
      end
      quiet_mode = (phase == 2);
      for (i = 0; i < N_RANDOM / 5; i++) send_body(random_body(), 1'b0, none);
      quiet_mode = 1'b0;
      drain();
    end

    $display("checked %0d result words over directed rows, register extremes",
             n_checked);
    $display("and five random phases with stalls and a long output hold-off");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("** body_integrate_step_top: PASSED **");
    end else begin
      $display("%0d errors, %0d words still expected", n_errors, expected_q.size());
      $display("** body_integrate_step_top: FAILED **");
    end
    $finish;
  end

endmodule
